FILE: design/lrurp_pkg.sv
package lrurp_pkg;

    localparam int NUM_BLOCKS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_REPLACE    = 2'd0,
        CMD_ACCESS     = 2'd1,
        CMD_INVALIDATE = 2'd2
    } t_command;

    typedef struct packed {
        t_command   command;
        logic [3:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic [3:0] victim_index;
        logic       victim_was_free;
    } t_out_item;

endpackage

FILE: design/lrurp_order_mem.sv
module lrurp_order_mem #(
    parameter int DEPTH = lrurp_pkg::NUM_BLOCKS_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [IW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [IW-1:0] o_rdata
);

    logic [IW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lru_replacement_policy_core.sv
// replace takes the lowest free block by stepping through the valid marks; if all are valid
// it evicts order[0] and moves it to the tail. access of a valid block moves it to the tail.
// invalidate, ignored commands and accesses of invalid blocks finish from idle. the order
// memory is walked one entry per cycle. one item at a time: busy is high until the result strobe.
// result is shown for one cycle with o_done; the receiver cannot stall.
// synchronous active-low reset clears valid marks and order length; the order memory is not cleared
module lru_replacement_policy_core #(
    parameter int NUM_BLOCKS = lrurp_pkg::NUM_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lrurp_pkg::t_in_item i_item,
    output logic                o_done,
    output lrurp_pkg::t_out_item o_result
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int SW = LW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_PREP,
        S_SHIFT
    } t_state;

    t_state                r_state;
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [LW-1:0]         r_len;
    logic [IW-1:0]         r_ptr;
    logic [IW-1:0]         r_blk;
    logic                  r_done;
    logic [3:0]            r_victim;
    logic                  r_free;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [IW-1:0]         mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [IW-1:0]         mem_rdata;

    logic                  ptr1_in;
    logic                  ptr2_in;
    logic                  blk_ok;
    logic [IW-1:0]         in_blk;

    // order positions ptr+1 and ptr+2 still inside the list
    assign ptr1_in = (SW'(r_ptr) + SW'(1)) < SW'(r_len);
    assign ptr2_in = (SW'(r_ptr) + SW'(2)) < SW'(r_len);
    assign blk_ok  = 32'(i_item.block_index) < NUM_BLOCKS;
    assign in_blk  = IW'(i_item.block_index);

    lrurp_order_mem #(
        .DEPTH (NUM_BLOCKS),
        .IW    (IW)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = r_blk;
        mem_raddr = '0;
        case (r_state)
            S_FREE: begin
                mem_waddr = IW'(r_len);
                mem_wdata = r_ptr;
                mem_we    = !r_valid[r_ptr];
            end
            S_SCAN: begin
                if (ptr1_in) begin
                    mem_raddr = IW'(SW'(r_ptr) + SW'(1));
                end
            end
            S_PREP: begin
                if (ptr1_in) begin
                    mem_raddr = IW'(SW'(r_ptr) + SW'(1));
                end
            end
            S_SHIFT: begin
                // pull the next entry down, or drop the moved block into the tail slot
                mem_we    = 1'b1;
                mem_wdata = ptr1_in ? mem_rdata : r_blk;
                if (ptr2_in) begin
                    mem_raddr = IW'(SW'(r_ptr) + SW'(2));
                end
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_len    <= '0;
            r_done   <= 1'b0;
            r_ptr    <= '0;
            r_blk    <= '0;
            r_victim <= '0;
            r_free   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_ptr    <= '0;
                        r_victim <= '0;
                        r_free   <= 1'b0;
                        case (i_item.command)
                            lrurp_pkg::CMD_REPLACE: begin
                                r_state <= S_FREE;
                            end
                            lrurp_pkg::CMD_ACCESS: begin
                                if (blk_ok && r_valid[in_blk]) begin
                                    r_blk   <= in_blk;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            lrurp_pkg::CMD_INVALIDATE: begin
                                r_valid <= '0;
                                r_len   <= '0;
                                r_done  <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_ptr]) begin
                        r_valid[r_ptr] <= 1'b1;
                        r_len          <= r_len + LW'(1);
                        r_victim       <= 4'(r_ptr);
                        r_free         <= 1'b1;
                        r_done         <= 1'b1;
                        r_state        <= S_IDLE;
                    end else if (32'(r_ptr) == NUM_BLOCKS - 1) begin
                        // all valid: the read port has held order[0] throughout
                        if (r_len != '0) begin
                            r_blk    <= mem_rdata;
                            r_victim <= 4'(mem_rdata);
                            r_ptr    <= '0;
                            r_state  <= S_PREP;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_ptr <= r_ptr + IW'(1);
                    end
                end
                S_SCAN: begin
                    if (mem_rdata == r_blk) begin
                        r_state <= S_PREP;
                    end else if (!ptr1_in) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + IW'(1);
                    end
                end
                S_PREP: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (ptr1_in) begin
                        r_ptr <= r_ptr + IW'(1);
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                     = (r_state != S_IDLE);
    assign o_done                   = r_done;
    assign o_result.victim_index    = r_victim;
    assign o_result.victim_was_free = r_free;

endmodule

FILE: sim/lru_replacement_policy_core_test.sv
`timescale 1ns / 1ps

module lru_replacement_policy_core_test;

    localparam int NBLK = lrurp_pkg::NUM_BLOCKS_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 460;

    typedef struct packed {
        lrurp_pkg::t_command cmd;
        logic [3:0]          blk;
        logic                typed;
        logic [3:0]          victim;
        logic                was_free;
    } t_dir_row;

    // hand-written expectations where the answer is obvious
    localparam int NUM_DIR = 26;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{lrurp_pkg::CMD_ACCESS,              4'd5,  1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_REPLACE,             4'd15, 1'b1, 4'd0,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd1,  1'b1},
        '{lrurp_pkg::CMD_ACCESS,              4'd0,  1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::t_command'(CMD_UNUSED),  4'd15, 1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_INVALIDATE,          4'd10, 1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd0,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd1,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd2,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd3,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd4,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd5,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd6,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd7,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd8,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd9,  1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd10, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd11, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd12, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd13, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd14, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd15, 1'b1},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_ACCESS,              4'd1,  1'b1, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_REPLACE,             4'd0,  1'b0, 4'd0,  1'b0},
        '{lrurp_pkg::CMD_ACCESS,              4'd15, 1'b1, 4'd0,  1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    lrurp_pkg::t_in_item  i_item;
    logic                 o_done;
    lrurp_pkg::t_out_item o_result;

    // shadow copy of the block state
    bit         blk_valid [NBLK];
    logic [3:0] lru_order [NBLK];
    int         lru_len;

    lrurp_pkg::t_out_item pending_victims [$];
    int                   err_count;

    lru_replacement_policy_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // drop the entry at pos and re-append blk as most recent
    function automatic void promote(input int pos, input logic [3:0] blk);
        for (int i = pos; i + 1 < lru_len; i++) begin
            lru_order[i] = lru_order[i + 1];
        end
        if (lru_len > 0) begin
            lru_order[lru_len - 1] = blk;
        end
    endfunction

    function automatic lrurp_pkg::t_out_item choose_victim(input lrurp_pkg::t_in_item it);
        lrurp_pkg::t_out_item res;
        int                   free_blk;
        res = '0;
        free_blk = -1;
        case (it.command)
            lrurp_pkg::CMD_REPLACE: begin
                for (int i = NBLK - 1; i >= 0; i--) begin
                    if (!blk_valid[i]) begin
                        free_blk = i;
                    end
                end
                if (free_blk >= 0) begin
                    blk_valid[free_blk] = 1'b1;
                    lru_order[lru_len] = free_blk[3:0];
                    lru_len++;
                    res.victim_index = free_blk[3:0];
                    res.victim_was_free = 1'b1;
                end else if (lru_len > 0) begin
                    res.victim_index = lru_order[0];
                    promote(0, lru_order[0]);
                end
            end
            lrurp_pkg::CMD_ACCESS: begin
                if (blk_valid[it.block_index]) begin
                    for (int i = 0; i < lru_len; i++) begin
                        if (lru_order[i] == it.block_index) begin
                            promote(i, it.block_index);
                            break;
                        end
                    end
                end
            end
            lrurp_pkg::CMD_INVALIDATE: begin
                foreach (blk_valid[i]) begin
                    blk_valid[i] = 1'b0;
                end
                lru_len = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly replaces and hits on valid blocks, some noise and rare flushes
    function automatic lrurp_pkg::t_in_item random_item();
        lrurp_pkg::t_in_item it;
        int                  r;
        r = int'($urandom_range(99));
        it.block_index = 4'($urandom_range(NBLK - 1));
        if (r < 45) begin
            it.command = lrurp_pkg::CMD_REPLACE;
        end else if (r < 82) begin
            it.command = lrurp_pkg::CMD_ACCESS;
            if (lru_len > 0) begin
                it.block_index = lru_order[$urandom_range(lru_len - 1)];
            end
        end else if (r < 92) begin
            it.command = lrurp_pkg::CMD_ACCESS;
        end else if (r < 98) begin
            it.command = lrurp_pkg::t_command'(CMD_UNUSED);
        end else begin
            it.command = lrurp_pkg::CMD_INVALIDATE;
        end
        return it;
    endfunction

    task automatic send_item(input lrurp_pkg::t_in_item it, input bit typed,
                             input lrurp_pkg::t_out_item typed_res, input int idle_pct);
        lrurp_pkg::t_out_item predicted;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = choose_victim(it);
        pending_victims.push_back(typed ? typed_res : predicted);
    endtask

    always @(posedge i_clk) begin
        lrurp_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_victims.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_victims.pop_front();
                if (o_result.victim_index !== want.victim_index) begin
                    report_mismatch("victim_index", int'(o_result.victim_index),
                                    int'(want.victim_index));
                end
                if (o_result.victim_was_free !== want.victim_was_free) begin
                    report_mismatch("victim_was_free", int'(o_result.victim_was_free),
                                    int'(want.victim_was_free));
                end
            end
        end
    end

    initial begin
        int                   idle_pct [3];
        lrurp_pkg::t_in_item  it;
        lrurp_pkg::t_out_item typed_res;
        idle_pct = '{14, 87, 0};
        err_count = 0;
        lru_len = 0;
        foreach (blk_valid[i]) begin
            blk_valid[i] = 1'b0;
            lru_order[i] = '0;
        end
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_DIR; n++) begin
            it.command = DIR_ROWS[n].cmd;
            it.block_index = DIR_ROWS[n].blk;
            typed_res.victim_index = DIR_ROWS[n].victim;
            typed_res.victim_was_free = DIR_ROWS[n].was_free;
            send_item(it, DIR_ROWS[n].typed, typed_res, idle_pct[0]);
        end

        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item(), 1'b0, '0, idle_pct[ph]);
            end
        end
        start <= 1'b0;

        while (pending_victims.size() != 0) @(posedge i_clk);
        repeat (2 * NBLK + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
